>>> sv/iirdf_pkg.sv
// Shared constants, types and control structures of the direct-form-I IIR filter.
package iirdf_pkg;

   localparam int ORDER_DEFAULT = 4;
   localparam int HIST_DEPTH    = 4;
   localparam int SAMPLE_W      = 16;
   localparam int COEF_W        = 32;
   localparam int FRAC_W        = 24;
   localparam int CSR_W         = 64;
   localparam int CSR_IDX_W     = 3;
   localparam int PROD_W        = COEF_W + SAMPLE_W;
   localparam int ACC_W         = PROD_W + 4;
   localparam int STEP_W        = $clog2(2 * HIST_DEPTH + 1);
   localparam int TAP_W         = $clog2(HIST_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] REG_B0_B1 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_B2_B3 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_B4_A1 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_A2_A3 = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_A4    = CSR_IDX_W'(4);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;

   typedef struct packed {
      coef_type [HIST_DEPTH:0] b;
      coef_type [HIST_DEPTH:0] a;
   } coef_set_type;

   typedef struct packed {
      logic              load;
      logic              mul_en;
      logic [STEP_W-1:0] step;
      logic              finish;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

>>> sv/iirdf_csr.sv
// Coefficient register file written through the configuration channel.
module iirdf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [iirdf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [iirdf_pkg::CSR_W-1:0]         csr_data,
   output iirdf_pkg::coef_set_type             coefs
);
   import iirdf_pkg::*;

   logic [CSR_W-1:0]  reg0_ff;
   logic [CSR_W-1:0]  reg1_ff;
   logic [CSR_W-1:0]  reg2_ff;
   logic [CSR_W-1:0]  reg3_ff;
   logic [COEF_W-1:0] reg4_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         reg0_ff <= CSR_W'(64'h0000_0000_0100_0000);
         reg1_ff <= '0;
         reg2_ff <= '0;
         reg3_ff <= '0;
         reg4_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_B0_B1: reg0_ff <= csr_data;
            REG_B2_B3: reg1_ff <= csr_data;
            REG_B4_A1: reg2_ff <= csr_data;
            REG_A2_A3: reg3_ff <= csr_data;
            REG_A4:    reg4_ff <= csr_data[COEF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      coefs.b[0] = reg0_ff[COEF_W-1:0];
      coefs.b[1] = reg0_ff[CSR_W-1:COEF_W];
      coefs.b[2] = reg1_ff[COEF_W-1:0];
      coefs.b[3] = reg1_ff[CSR_W-1:COEF_W];
      coefs.b[4] = reg2_ff[COEF_W-1:0];
      coefs.a[0] = '0;
      coefs.a[1] = reg2_ff[CSR_W-1:COEF_W];
      coefs.a[2] = reg3_ff[COEF_W-1:0];
      coefs.a[3] = reg3_ff[CSR_W-1:COEF_W];
      coefs.a[4] = reg4_ff;
   end

endmodule

>>> sv/iirdf_ctrl.sv
// Sequencer that steps the shared multiply-accumulate through the filter taps.
module iirdf_ctrl #(
   parameter int ORDER = iirdf_pkg::ORDER_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output iirdf_pkg::dp_cmd_type     cmd,
   input  iirdf_pkg::dp_status_type  status
);
   import iirdf_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * ORDER);

   logic [1:0]        state_ff;
   logic [1:0]        state_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd.load   = 1'b0;
      cmd.mul_en = 1'b0;
      cmd.step   = step_ff;
      cmd.finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.mul_en = 1'b1;
            step_in    = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

>>> sv/iirdf_dp.sv
// Datapath with sample history, one multiplier, accumulator and rounding output stage.
module iirdf_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  iirdf_pkg::dp_cmd_type              cmd,
   output iirdf_pkg::dp_status_type           status,
   input  iirdf_pkg::coef_set_type            coefs,
   input  logic [iirdf_pkg::SAMPLE_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [iirdf_pkg::SAMPLE_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser
);
   import iirdf_pkg::*;

   localparam int Y_W = ACC_W - FRAC_W;

   sample_type                  x_ff;
   sample_type [HIST_DEPTH-1:0] xh_ff;
   sample_type [HIST_DEPTH-1:0] yh_ff;
   sample_type [HIST_DEPTH:0]   xs;
   sample_type [HIST_DEPTH:0]   ys;

   logic [STEP_W:0]             step_p1;
   logic [TAP_W-1:0]            tap;
   logic                        is_fb;
   coef_type                    op_coef;
   sample_type                  op_sample;

   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [PROD_W-1:0]    prod_in;
   logic                        sub_ff;
   logic                        prod_vld_ff;
   logic signed [ACC_W-1:0]     acc_ff;
   logic signed [ACC_W-1:0]     acc_in;
   logic signed [ACC_W-1:0]     prod_ext;

   logic signed [ACC_W-1:0]     rnd;
   logic [Y_W-1:0]              y_full;
   logic                        sat;
   sample_type                  y_sat;

   logic                        rsp_valid_ff;
   sample_type                  rsp_data_ff;
   logic                        rsp_sat_ff;

   always_comb begin
      xs[0] = x_ff;
      ys[0] = '0;
      for (int i = 1; i <= HIST_DEPTH; i++) begin
         xs[i] = xh_ff[i-1];
         ys[i] = yh_ff[i-1];
      end
   end

   assign step_p1   = {1'b0, cmd.step} + 1'b1;
   assign tap       = step_p1[TAP_W:1];
   assign is_fb     = (cmd.step != '0) && !cmd.step[0];
   assign op_coef   = is_fb ? coefs.a[tap] : coefs.b[tap];
   assign op_sample = is_fb ? ys[tap] : xs[tap];
   assign prod_in   = $signed(op_coef) * $signed(op_sample);

   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign acc_in   = sub_ff ? (acc_ff - prod_ext) : (acc_ff + prod_ext);

   assign rnd    = acc_ff + (ACC_W'(1) <<< (FRAC_W - 1));
   assign y_full = rnd[ACC_W-1:FRAC_W];
   assign sat    = !((&y_full[Y_W-1:SAMPLE_W-1]) || !(|y_full[Y_W-1:SAMPLE_W-1]));

   always_comb begin
      if (!sat) begin
         y_sat = y_full[SAMPLE_W-1:0];
      end else if (y_full[Y_W-1]) begin
         y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= req_tdata;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
         sub_ff  <= is_fb;
      end
      if (cmd.load) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_in;
      end
      if (cmd.finish) begin
         rsp_data_ff <= y_sat;
         rsp_sat_ff  <= sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         xh_ff        <= '0;
         yh_ff        <= '0;
      end else begin
         prod_vld_ff <= cmd.mul_en;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
            xh_ff        <= {xh_ff[HIST_DEPTH-2:0], x_ff};
            yh_ff        <= {yh_ff[HIST_DEPTH-2:0], y_sat};
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tuser       = rsp_sat_ff;

endmodule

>>> sv/iir_direct_form_filter.sv
// Top level of the streaming direct-form-I IIR filter.
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_tvalid/req_tready  tdata: sample_in
//   rsp       out        rsp_tvalid/rsp_tready  tdata: sample_out, tuser: saturated
//   csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// After acceptance each item reaches the result register through the states RUN, DRAIN and OUT.
// The single multiplier works through 2*ORDER+1 taps in turn in RUN, DRAIN adds the last
// product and OUT rounds into the output register once it is free. The next item is accepted
// once the previous one has reached the output register, not while it is still in progress.
// Reset clears the sample history and loads b0 = 1.0 with all other coefficients zero.
// A stalled result holds in the output register while the next item is computed.
module iir_direct_form_filter #(
   parameter int ORDER = iirdf_pkg::ORDER_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [iirdf_pkg::SAMPLE_W-1:0]    req_tdata,   // [15:0] sample_in
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [iirdf_pkg::SAMPLE_W-1:0]    rsp_tdata,   // [15:0] sample_out
   output logic                              rsp_tuser,   // [0] saturated
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [iirdf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [iirdf_pkg::CSR_W-1:0]       csr_data
);
   import iirdf_pkg::*;

   coef_set_type  coefs;
   dp_cmd_type    cmd;
   dp_status_type status;

   iirdf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coefs     (coefs)
   );

   iirdf_ctrl #(
      .ORDER (ORDER)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   iirdf_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .coefs      (coefs),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> tb/sv/iirdf_checker.sv
// Checker that predicts each filtered sample from the accepted items and compares the outputs.
module iirdf_checker #(
   parameter int ORDER = iirdf_pkg::ORDER_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [iirdf_pkg::SAMPLE_W-1:0]  req_tdata,   // [15:0] sample_in
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [iirdf_pkg::SAMPLE_W-1:0]  rsp_tdata,   // [15:0] sample_out
   input  logic                            rsp_tuser,   // [0] saturated
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [iirdf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [iirdf_pkg::CSR_W-1:0]     csr_data,
   input  logic                            done,
   output int                              mismatches,
   output int                              outstanding,
   output int                              clipped_count
);
   import iirdf_pkg::*;

   localparam longint OUT_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint OUT_MIN = -(longint'(1) << (SAMPLE_W - 1));
   localparam longint ROUND_HALF = longint'(1) << (FRAC_W - 1);

   typedef struct {
      sample_type value;
      logic       clipped;
   } filter_output_type;

   logic [CSR_W-1:0]  coef_regs [0:4];
   sample_type        past_inputs [0:HIST_DEPTH-1];
   sample_type        past_outputs [0:HIST_DEPTH-1];
   filter_output_type expected_outputs [$];
   int                outputs_seen;
   logic              leftovers_checked;

   task automatic report_mismatch(input string msg);
      if (mismatches < 30) begin
         $display("mismatch: %s", msg);
      end
      mismatches++;
   endtask

   function automatic coef_type feedforward_coef(input int k);
      case (k)
         0: return coef_regs[REG_B0_B1][COEF_W-1:0];
         1: return coef_regs[REG_B0_B1][2*COEF_W-1:COEF_W];
         2: return coef_regs[REG_B2_B3][COEF_W-1:0];
         3: return coef_regs[REG_B2_B3][2*COEF_W-1:COEF_W];
         default: return coef_regs[REG_B4_A1][COEF_W-1:0];
      endcase
   endfunction

   function automatic coef_type feedback_coef(input int k);
      case (k)
         1: return coef_regs[REG_B4_A1][2*COEF_W-1:COEF_W];
         2: return coef_regs[REG_A2_A3][COEF_W-1:0];
         3: return coef_regs[REG_A2_A3][2*COEF_W-1:COEF_W];
         default: return coef_regs[REG_A4][COEF_W-1:0];
      endcase
   endfunction

   task automatic apply_coef_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      case (idx)
         REG_B0_B1, REG_B2_B3, REG_B4_A1, REG_A2_A3: coef_regs[idx] = data;
         REG_A4: coef_regs[REG_A4] = {{(CSR_W-COEF_W){1'b0}}, data[COEF_W-1:0]};
         default: ;
      endcase
   endtask

   task automatic predict_output(input sample_type x);
      longint            acc;
      longint            rounded;
      filter_output_type result;
      int                k;
      acc = longint'(feedforward_coef(0)) * longint'(x);
      for (k = 1; k <= ORDER; k++) begin
         acc += longint'(feedforward_coef(k)) * longint'(past_inputs[k-1]);
         acc -= longint'(feedback_coef(k)) * longint'(past_outputs[k-1]);
      end
      rounded = (acc + ROUND_HALF) >>> FRAC_W;
      result.clipped = 1'b1;
      if (rounded > OUT_MAX) begin
         result.value = sample_type'(OUT_MAX);
      end else if (rounded < OUT_MIN) begin
         result.value = sample_type'(OUT_MIN);
      end else begin
         result.value = sample_type'(rounded);
         result.clipped = 1'b0;
      end
      for (k = HIST_DEPTH - 1; k > 0; k--) begin
         past_inputs[k] = past_inputs[k-1];
         past_outputs[k] = past_outputs[k-1];
      end
      past_inputs[0] = x;
      past_outputs[0] = result.value;
      expected_outputs.push_back(result);
   endtask

   task automatic check_output();
      filter_output_type want;
      if (expected_outputs.size() == 0) begin
         report_mismatch($sformatf("output %0d arrived with no sample pending",
                                   $signed(rsp_tdata)));
         return;
      end
      want = expected_outputs.pop_front();
      if (rsp_tdata !== want.value) begin
         report_mismatch($sformatf("output %0d: sample_out %0d, expected %0d",
                                   outputs_seen, $signed(rsp_tdata), want.value));
      end
      if (rsp_tuser !== want.clipped) begin
         report_mismatch($sformatf("output %0d: saturated %b, expected %b",
                                   outputs_seen, rsp_tuser, want.clipped));
      end
      if (want.clipped) begin
         clipped_count++;
      end
      outputs_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         coef_regs[REG_B0_B1] <= 64'h0000_0000_0100_0000;
         coef_regs[REG_B2_B3] <= '0;
         coef_regs[REG_B4_A1] <= '0;
         coef_regs[REG_A2_A3] <= '0;
         coef_regs[REG_A4] <= '0;
         for (int k = 0; k < HIST_DEPTH; k++) begin
            past_inputs[k] <= '0;
            past_outputs[k] <= '0;
         end
         expected_outputs.delete();
         outstanding <= 0;
         mismatches = 0;
         clipped_count = 0;
         outputs_seen = 0;
         leftovers_checked = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            apply_coef_write(csr_index, csr_data);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_output();
         end
         if (req_tvalid && req_tready) begin
            predict_output(sample_type'(req_tdata));
         end
         outstanding <= expected_outputs.size();
         if (done && !leftovers_checked) begin
            foreach (expected_outputs[i]) begin
               report_mismatch($sformatf("expected output %0d never arrived",
                                         expected_outputs[i].value));
            end
            leftovers_checked = 1'b1;
         end
      end
   end

endmodule

>>> tb/sv/testbench.sv
// Testbench top that drives samples and coefficient writes into the IIR filter and reports the verdict.
module testbench;
   import iirdf_pkg::*;

   localparam int ORDER         = 4;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 195;
   localparam int DRAIN_CYCLES  = 2 * ORDER + 8;
   localparam int LONG_HOLD     = 300;
   localparam int CYCLE_LIMIT   = 1000000;

   localparam logic [COEF_W-1:0] COEF_ONE        = 32'h0100_0000;
   localparam logic [COEF_W-1:0] COEF_MINUS_ONE  = 32'hFF00_0000;
   localparam logic [COEF_W-1:0] COEF_HALF       = 32'h0080_0000;
   localparam logic [COEF_W-1:0] COEF_MINUS_HALF = 32'hFF80_0000;
   localparam logic [COEF_W-1:0] COEF_MAX        = 32'h7FFF_FFFF;
   localparam logic [COEF_W-1:0] COEF_MIN        = 32'h8000_0000;

   typedef enum int {
      STYLE_GENTLE,
      STYLE_WILD,
      STYLE_EXTREME,
      STYLE_BOUNCY
   } coef_style_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [SAMPLE_W-1:0]  req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]  rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data = '0;
   logic                 done = 1'b0;

   int mismatches;
   int outstanding;
   int clipped_count;
   int cycle_count = 0;
   int samples_sent = 0;
   int coef_sets = 0;
   int ready_gap;
   int rsp_seen;
   int next_hold_at;
   int holds_done;

   logic [COEF_W-1:0] set_b [0:HIST_DEPTH];
   logic [COEF_W-1:0] set_a [1:HIST_DEPTH];

   iir_direct_form_filter #(.ORDER(ORDER)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   iirdf_checker #(.ORDER(ORDER)) filter_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .done          (done),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .clipped_count (clipped_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // The output side stalls at random and twice holds off long enough to back up the input.
   always @(posedge clock) begin
      int ready_pick;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_gap <= 0;
         rsp_seen <= 0;
         next_hold_at <= 500;
         holds_done <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen <= rsp_seen + 1;
         end
         if (ready_gap != 0) begin
            rsp_tready <= 1'b0;
            ready_gap <= ready_gap - 1;
         end else if (rsp_seen >= next_hold_at) begin
            rsp_tready <= 1'b0;
            ready_gap <= LONG_HOLD;
            next_hold_at <= next_hold_at + 800;
            holds_done <= holds_done + 1;
         end else if ((rsp_seen / 64) % 5 == 4) begin
            rsp_tready <= 1'b1;
         end else begin
            ready_pick = idle_gap();
            if (ready_pick == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               ready_gap <= ready_pick - 1;
            end
         end
      end
   end

   task automatic send_sample(input sample_type s, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= s;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic zero_coef_set();
      for (int k = 0; k <= HIST_DEPTH; k++) begin
         set_b[k] = '0;
      end
      for (int k = 1; k <= HIST_DEPTH; k++) begin
         set_a[k] = '0;
      end
   endtask

   task automatic load_coefs();
      wait_idle();
      write_csr(REG_B0_B1, {set_b[1], set_b[0]});
      write_csr(REG_B2_B3, {set_b[3], set_b[2]});
      write_csr(REG_B4_A1, {set_a[1], set_b[4]});
      write_csr(REG_A2_A3, {set_a[3], set_a[2]});
      write_csr(REG_A4, {COEF_W'($urandom()), set_a[4]});
      coef_sets++;
   endtask

   function automatic logic [CSR_IDX_W-1:0] unused_index();
      return REG_A4 + CSR_IDX_W'($urandom_range(1, 3));
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef(input coef_style_type style,
                                                   input bit feedback);
      int span;
      case (style)
         STYLE_GENTLE: begin
            span = feedback ? (1 << 21) : (1 << 22);
            return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
         end
         STYLE_WILD: return COEF_W'($urandom());
         STYLE_EXTREME: begin
            case ($urandom_range(4))
               0: return COEF_MAX;
               1: return COEF_MIN;
               2: return COEF_ONE;
               3: return COEF_MINUS_ONE;
               default: return '0;
            endcase
         end
         default: begin
            span = 1 << 23;
            return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
         end
      endcase
   endfunction

   function automatic sample_type next_sample();
      case ($urandom_range(9))
         0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         1: return '0;
         2, 3, 4: return sample_type'(int'($urandom_range(0, 1024)) - 512);
         default: return sample_type'($urandom());
      endcase
   endfunction

   initial begin
      coef_style_type style;
      int gap;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset coefficients pass samples straight through, extremes included.
      send_sample(16'sh7FFF, 0);
      send_sample(16'sh8000, 0);
      send_sample(16'sh0000, 0);
      send_sample(-16'sd1, 0);
      send_sample(16'sd1, 0);
      send_sample(16'sh5555, 0);
      send_sample(16'shAAAA, 0);

      // With a gain of one half, ties round toward plus infinity.
      zero_coef_set();
      set_b[0] = COEF_HALF;
      load_coefs();
      send_sample(16'sd1, 0);
      send_sample(-16'sd1, 0);
      send_sample(16'sd3, 0);
      send_sample(-16'sd3, 0);

      // The largest gains of either sign drive the output into clipping.
      set_b[0] = COEF_MAX;
      load_coefs();
      send_sample(16'sh7FFF, 0);
      send_sample(16'sh8000, 0);
      send_sample(16'sd1, 0);
      for (int k = 0; k <= HIST_DEPTH; k++) begin
         set_b[k] = COEF_MIN;
      end
      for (int k = 1; k <= HIST_DEPTH; k++) begin
         set_a[k] = COEF_MIN;
      end
      load_coefs();
      send_sample(16'sh7FFF, 0);
      send_sample(16'sh8000, 0);
      send_sample(16'sh7FFF, 0);
      for (int k = 0; k <= HIST_DEPTH; k++) begin
         set_b[k] = COEF_MAX;
      end
      for (int k = 1; k <= HIST_DEPTH; k++) begin
         set_a[k] = COEF_MAX;
      end
      load_coefs();
      send_sample(16'sh8000, 0);
      send_sample(16'sh7FFF, 0);
      send_sample(16'sh0000, 0);

      // Impulse response of a one-pole feedback with a write to an unused index in between.
      zero_coef_set();
      set_b[0] = COEF_ONE;
      set_a[1] = COEF_MINUS_HALF;
      load_coefs();
      write_csr(unused_index(), {$urandom(), $urandom()});
      send_sample(16'sh4000, 0);
      send_sample(16'sh0000, 0);
      send_sample(16'sh0000, 0);
      send_sample(16'sh0000, 0);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         style = coef_style_type'(phase % 4);
         for (int k = 0; k <= HIST_DEPTH; k++) begin
            set_b[k] = pick_coef(style, 1'b0);
         end
         for (int k = 1; k <= HIST_DEPTH; k++) begin
            set_a[k] = pick_coef(style, 1'b1);
         end
         load_coefs();
         if (phase % 3 == 1) begin
            write_csr(unused_index(), {$urandom(), $urandom()});
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ((samples_sent / 64) % 5 == 2) begin
               gap = 0;
            end else begin
               gap = idle_gap();
            end
            send_sample(next_sample(), gap);
         end
      end

      wait_idle();
      done <= 1'b1;
      repeat (2) @(posedge clock);
      $display("Filtered %0d samples under %0d coefficient settings; %0d outputs clipped.",
               samples_sent, coef_sets, clipped_count);
      $display("The output side held off %0d times for %0d cycles with samples still offered.",
               holds_done, LONG_HOLD);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/iirdf_pkg.sv
sv/iirdf_csr.sv
sv/iirdf_ctrl.sv
sv/iirdf_dp.sv
sv/iir_direct_form_filter.sv
tb/sv/iirdf_checker.sv
tb/sv/testbench.sv
